/* rtl/ipf_pkg.sv */
package ipf_pkg;

  // Operand and product widths of the shared multiplier.
  localparam int unsigned MUL_A_W = 41;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Width of the final update sums before saturation.
  localparam int unsigned SUM_W = 52;

  // Item kinds and correction targets.
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_CORRECT = 1'b1;
  localparam logic TGT_POS      = 1'b0;
  localparam logic TGT_VEL      = 1'b1;

  // A weight of 1.0 in Q8.8.
  localparam logic [8:0] WEIGHT_ONE = 9'd256;

  // Sequencer states: one multiplier issue or combine step per state.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_FIN
  } state_e;

  // Request to the shared multiplier.
  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  // Saturate a wide signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [SUM_W-1:0] x);
    logic [SUM_W-32:0] top;
    logic [31:0]       res;
    top = x[SUM_W-1:31];
    if ((&top) || !(|top)) begin
      res = x[31:0];
    end else if (x[SUM_W-1]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

/* rtl/ipf_mul.sv */
// Shared signed multiplier with a registered product.
// The product holds its value on cycles without a request.
module ipf_mul
  import ipf_pkg::*;
(
  input  logic                       clk_i,
  input  mul_req_t                   req_i,
  output logic signed [MUL_P_W-1:0]  prod_o
);

  logic signed [MUL_P_W-1:0] prod_q;
  logic signed [MUL_P_W-1:0] prod_d;

  // Full signed product of both operands.
  assign prod_d = $signed(req_i.a) * $signed(req_i.b);

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/inertial_position_filter_unit.sv */
// One-axis inertial position filter. It keeps a position and a velocity
// estimate in signed Q16.16 and returns both after every input word. A
// predict word integrates the acceleration over dt; a correct word adds
// err*weight*dt to position (with the velocity coupled through the weight
// limited to 1.0) or to velocity. All updates round half up and saturate.
// Each word runs through a small sequencer that uses a single 41x17 signed
// multiplier at most once per step; a correct word adds a coupling multiply
// step that a predict word skips, and no new word is taken until the last
// one is done. Results wait in an output register, so the next word is taken
// while a result is still waiting. Both estimates reset to zero.
module inertial_position_filter_unit
  import ipf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] dt_i,
  input  logic [31:0] accel_i,
  input  logic [31:0] err_i,
  input  logic [15:0] weight_i,
  input  logic        target_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] position_o,
  output logic [31:0] velocity_o
);

  state_e state_q, state_d;

  // Captured input word.
  logic        kind_q;
  logic        tgt_q;
  logic [15:0] dt_q;
  logic [31:0] opnd_q;
  logic [15:0] w_q;

  // Intermediate products and sums.
  logic signed [47:0]        adt_q;
  logic signed [63:0]        wide_q;
  logic signed [47:0]        half_q;
  logic signed [MUL_P_W-1:0] prod;
  mul_req_t                  mul_req;

  // Estimates and output register.
  logic [31:0] pos_q, vel_q;
  logic [31:0] out_pos_q, out_vel_q;
  logic        out_valid_q;

  logic in_fire, commit;
  logic [8:0] wc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign wc         = (w_q > {7'd0, WEIGHT_ONE}) ? WEIGHT_ONE : w_q[8:0];

  ipf_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_M0;
        end
      end
      ST_M0: state_d = ST_M1;
      ST_M1: state_d = ST_M2;
      ST_M2: state_d = ST_M3;
      ST_M3: state_d = ST_M4;
      ST_M4: state_d = (kind_q == KIND_PREDICT) ? ST_FIN : ST_M5;
      ST_M5: state_d = ST_FIN;
      ST_FIN: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Multiplier operands for each step.
  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = {1'b0, dt_q};
    unique case (state_q)
      ST_M0: begin
        mul_req.en = 1'b1;
        mul_req.a  = (kind_q == KIND_PREDICT) ? {{9{opnd_q[31]}}, opnd_q}
                                              : {25'd0, w_q};
      end
      ST_M1: begin
        mul_req.en = 1'b1;
        if (kind_q == KIND_PREDICT) begin
          mul_req.a = {9'd0, prod[31:0]};
        end else begin
          mul_req.a = {{9{opnd_q[31]}}, opnd_q};
          mul_req.b = {1'b0, prod[15:0]};
        end
      end
      ST_M2: begin
        mul_req.en = 1'b1;
        if (kind_q == KIND_PREDICT) begin
          mul_req.a = {{25{adt_q[47]}}, adt_q[47:32]};
        end else begin
          mul_req.a = {{9{opnd_q[31]}}, opnd_q};
          mul_req.b = {1'b0, adt_q[31:16]};
        end
      end
      ST_M3: begin
        if (kind_q == KIND_PREDICT) begin
          mul_req.en = 1'b1;
          mul_req.a  = {{9{vel_q[31]}}, vel_q};
        end
      end
      ST_M5: begin
        mul_req.en = 1'b1;
        mul_req.a  = half_q[MUL_A_W-1:0];
        mul_req.b  = {8'd0, wc};
      end
      ST_IDLE, ST_M4, ST_FIN: begin
        mul_req.en = 1'b0;
      end
      default: begin
        mul_req.en = 1'b0;
      end
    endcase
  end

  // Rounding of the accumulated product.
  logic signed [63:0] r17, r24;
  assign r17 = wide_q + 64'sd65536;
  assign r24 = wide_q + 64'sd8388608;

  // Final update sums.
  logic signed [SUM_W-1:0] p52, v52, half52, adt52, vdt52, cpl52;
  logic signed [SUM_W-1:0] psum_pred, vsum_pred, psum_cor, vsum_cpl, vsum_cor;
  logic [31:0]             pos_new, vel_new;

  assign p52    = {{(SUM_W-32){pos_q[31]}}, pos_q};
  assign v52    = {{(SUM_W-32){vel_q[31]}}, vel_q};
  assign half52 = {{(SUM_W-48){half_q[47]}}, half_q};
  assign adt52  = {{(SUM_W-48){adt_q[47]}}, adt_q};
  assign vdt52  = {{(SUM_W-48){prod[47]}}, prod[47:0]};
  assign cpl52  = {{(SUM_W-49){prod[48]}}, prod[48:0]} + 52'sd128;

  assign psum_pred = ((p52 <<< 16) + vdt52 + half52 + 52'sd32768) >>> 16;
  assign vsum_pred = ((v52 <<< 16) + adt52 + 52'sd32768) >>> 16;
  assign psum_cor  = p52 + half52;
  assign vsum_cpl  = v52 + (cpl52 >>> 8);
  assign vsum_cor  = v52 + half52;

  always_comb begin
    pos_new = pos_q;
    vel_new = vel_q;
    if (kind_q == KIND_PREDICT) begin
      pos_new = sat32(psum_pred);
      vel_new = sat32(vsum_pred);
    end else if (tgt_q == TGT_POS) begin
      pos_new = sat32(psum_cor);
      vel_new = sat32(vsum_cpl);
    end else begin
      vel_new = sat32(vsum_cor);
    end
  end

  // Datapath registers: capture, partial products, rounding and the output register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      tgt_q  <= target_i;
      dt_q   <= dt_i;
      opnd_q <= (kind_i == KIND_PREDICT) ? accel_i : err_i;
      w_q    <= weight_i;
    end
    if (state_q == ST_M1) begin
      adt_q <= (kind_q == KIND_PREDICT) ? prod[47:0] : {16'd0, prod[31:0]};
    end
    if (state_q == ST_M2) begin
      wide_q <= {{(64-MUL_P_W){prod[MUL_P_W-1]}}, prod};
    end
    if (state_q == ST_M3) begin
      if (kind_q == KIND_PREDICT) begin
        wide_q <= wide_q + $signed({prod[31:0], 32'd0});
      end else begin
        wide_q <= wide_q + $signed({prod[47:0], 16'd0});
      end
    end
    if (state_q == ST_M4) begin
      if (kind_q == KIND_PREDICT) begin
        half_q <= {r17[63], r17[63:17]};
      end else begin
        half_q <= {{8{r24[63]}}, r24[63:24]};
      end
    end
    if (commit) begin
      out_pos_q <= pos_new;
      out_vel_q <= vel_new;
    end
  end

  // Control state and estimates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        pos_q       <= pos_new;
        vel_q       <= vel_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign velocity_o  = out_vel_q;

  // A finished word waits in the last step while the output is still full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i) |=> state_q == ST_FIN)
    else $error("sequencer left the final step while the output was full");

  // A new result only appears out of the final step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result appeared without a finished word");

  // An accepted word starts the multiply sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_M0)
    else $error("accepted word did not start the sequence");

  // A predict word skips the coupling multiply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M4 && kind_q == KIND_PREDICT) |=> state_q == ST_FIN)
    else $error("predict word entered the coupling step");

endmodule
